/* rtl/ple_pkg.sv */
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int DataWidth = 32;
  localparam int PosWidth  = 9;
  localparam int StatWidth = 2;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;
  localparam logic [1:0] KIND_UPDATE = 2'd3;

  // Result status codes.
  localparam logic [StatWidth-1:0] ST_DONE   = 2'd0;
  localparam logic [StatWidth-1:0] ST_BADPOS = 2'd1;
  localparam logic [StatWidth-1:0] ST_FULL   = 2'd2;

  // What every cell of the row does in a given cycle.
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_DELETE,
    MODE_WRITE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t           mode;
    logic [DataWidth-1:0] wdata;
  } cell_ctrl_t;

endpackage

/* rtl/ple_cell.sv */
// One storage cell of the list row, shifting with its neighbors.
module ple_cell
  import ple_pkg::*;
#(
  parameter int IW    = 8,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [IW-1:0]        slot,
  input  logic [DataWidth-1:0] left_q,
  input  logic [DataWidth-1:0] right_q,
  output logic [DataWidth-1:0] q,
  output logic [DataWidth-1:0] tap
);

  localparam logic [IW-1:0] MyIndex = IW'(INDEX);

  logic [DataWidth-1:0] entry;
  logic [DataWidth-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    unique case (ctrl.mode)
      MODE_HOLD: begin
        entry_next = entry;
      end
      MODE_INSERT: begin
        // Cells above the slot take their lower neighbor; the slot takes the new word.
        if (MyIndex > slot) begin
          entry_next = left_q;
        end else if (MyIndex == slot) begin
          entry_next = ctrl.wdata;
        end
      end
      MODE_DELETE: begin
        if (MyIndex >= slot) begin
          entry_next = right_q;
        end
      end
      MODE_WRITE: begin
        if (MyIndex == slot) begin
          entry_next = ctrl.wdata;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign q   = entry;
  assign tap = (MyIndex == slot) ? entry : '0;

endmodule

/* rtl/ple_tap_tree.sv */
// OR reduction of the masked cell taps into one read word.
module ple_tap_tree
  import ple_pkg::*;
#(
  parameter int N = 256
) (
  input  logic [DataWidth-1:0] taps [N],
  output logic [DataWidth-1:0] rd
);

  always_comb begin
    rd = '0;
    for (int i = 0; i < N; i++) begin
      rd = rd | taps[i];
    end
  end

endmodule

/* rtl/positional_list_engine.sv */
// Top level of the positional list engine: cell row, control and output register.
// The engine keeps an ordered list of up to LIST_DEPTH signed 32-bit words in a row
// of register cells and serves one request per transaction on the input stream:
// insert before a 1-based position (appending when the position lies past the end),
// delete and return, get, or update in place. Every request yields exactly one result
// transaction carrying the read word, a status code and the list length afterwards.
// A request is decided and applied in the cycle it is accepted, because all cells
// shift toward or away from the target slot together, so the engine sustains one
// transaction per clock; the result sits in an output register, and a new request is
// taken whenever that register is empty or being drained in the same cycle. Nothing
// is taken while reset is held. The depth of the read path is set by the OR tree
// that collects the addressed cell.
// Entries need no clearing after reset: only the entry count resets, and nothing at
// or above the count is ever returned.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int LIST_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [8:0] position, [40:9] new_value, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [31:0] read_value, [33:32] status,
                                     // [42:34] list_length, rest zero
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int W  = (CW > PosWidth) ? CW : PosWidth;
  localparam logic [W-1:0] DepthW = W'(LIST_DEPTH);

  // Request fields.
  logic [1:0]           kind;
  logic [PosWidth-1:0]  position;
  logic [DataWidth-1:0] new_value;

  assign kind      = s_axis_tuser;
  assign position  = s_axis_tdata[PosWidth-1:0];
  assign new_value = s_axis_tdata[PosWidth +: DataWidth];

  logic accept;
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Number of valid entries in the row.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [W-1:0] pos_w;
  logic [W-1:0] count_w;
  logic [W-1:0] slot_w;
  logic [W-1:0] count_next_w;
  logic         pos_zero;
  logic         is_full;
  logic         in_range;
  logic         op_ok;
  logic         reads;
  logic [StatWidth-1:0] status;

  cell_ctrl_t           ctrl;
  logic [IW-1:0]        slot;
  logic [DataWidth-1:0] tap_rd;
  logic [DataWidth-1:0] read_value;

  assign pos_w    = W'(position);
  assign count_w  = W'(count);
  assign pos_zero = (position == '0);
  assign is_full  = (count_w == DepthW);
  assign in_range = (pos_w <= count_w);

  // Decide status, the target slot and what the cell row does this cycle.
  always_comb begin
    status    = ST_DONE;
    op_ok     = 1'b0;
    reads     = 1'b0;
    slot_w    = pos_w - W'(1);
    ctrl.mode = MODE_HOLD;
    ctrl.wdata = new_value;
    if (pos_zero) begin
      status = ST_BADPOS;
    end else begin
      unique case (kind)
        KIND_INSERT: begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            op_ok = 1'b1;
            // A position past the end appends at the current count.
            if (pos_w > count_w) begin
              slot_w = count_w;
            end
          end
        end
        KIND_DELETE, KIND_GET, KIND_UPDATE: begin
          if (!in_range) begin
            status = ST_BADPOS;
          end else begin
            op_ok = 1'b1;
            reads = (kind == KIND_DELETE) || (kind == KIND_GET);
          end
        end
        default: begin
          status = ST_BADPOS;
        end
      endcase
    end
    if (accept && op_ok) begin
      unique case (kind)
        KIND_INSERT: ctrl.mode = MODE_INSERT;
        KIND_DELETE: ctrl.mode = MODE_DELETE;
        KIND_UPDATE: ctrl.mode = MODE_WRITE;
        KIND_GET:    ctrl.mode = MODE_HOLD;
        default:     ctrl.mode = MODE_HOLD;
      endcase
    end
  end

  assign slot = slot_w[IW-1:0];

  // Count after the request, as seen by the result.
  always_comb begin
    count_next_w = count_w;
    if (op_ok && (kind == KIND_INSERT)) begin
      count_next_w = count_w + W'(1);
    end else if (op_ok && (kind == KIND_DELETE)) begin
      count_next_w = count_w - W'(1);
    end
    count_next = count_next_w[CW-1:0];
  end

  // Row of cells; each cell sees its two neighbors.
  logic [DataWidth-1:0] cell_q   [LIST_DEPTH];
  logic [DataWidth-1:0] cell_tap [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [DataWidth-1:0] left_q;
    logic [DataWidth-1:0] right_q;
    if (i == 0) begin : g_first
      assign left_q = new_value;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    ple_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .slot    (slot),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .tap     (cell_tap[i])
    );
  end

  ple_tap_tree #(
    .N (LIST_DEPTH)
  ) u_tap_tree (
    .taps (cell_tap),
    .rd   (tap_rd)
  );

  assign read_value = reads ? tap_rd : '0;

  // Entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {5'd0, count_next_w[PosWidth-1:0], status, read_value};
    end
  end

`ifndef SYNTHESIS
  // The entry count never exceeds the depth of the row.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= DepthW)
    else $error("entry count above list depth");

  // The count moves only when a request is accepted.
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count changed without a request");

  // A rejected request leaves the list length unchanged.
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (status != ST_DONE) |=> $stable(count))
    else $error("rejected request changed the entry count");

  // Rejected results carry a zero read word.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] != ST_DONE) |-> (m_axis_tdata[31:0] == '0))
    else $error("rejected result with nonzero read value");
`endif

endmodule

/* dv/tb_positional_list_engine.sv */
// Self-checking stream testbench for the positional list engine.
`timescale 1ns / 100ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int ListDepth  = 256;
  localparam int CycleLimit = 200000;
  localparam int MaxReports = 10;

  // One request as the stimulus side sees it, plus its pacing.
  typedef struct {
    logic [1:0]          kind;
    logic [PosWidth-1:0] position;
    logic [31:0]         new_value;
    int unsigned         gap;    // idle cycles before the request is offered
    bit                  drain;  // hold the request until every result is back
  } request_t;

  // One result as the engine should report it.
  typedef struct {
    logic [31:0]          read_value;
    logic [StatWidth-1:0] status;
    logic [PosWidth-1:0]  list_length;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // [8:0] position, [40:9] new_value, rest zero
  logic [1:0]  s_axis_tuser = '0;  // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [31:0] read_value, [33:32] status,
                                   // [42:34] list_length, rest zero

  positional_list_engine #(
    .LIST_DEPTH(ListDepth)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the list contents, updated the moment a request is accepted.
  logic [31:0] mirror_words [ListDepth];
  int          mirror_len = 0;
  int          peak_len = 0;

  request_t    pending_requests[$];
  outcome_t    awaited_results[$];
  request_t    offered_request;
  outcome_t    wanted;

  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_waited = 0;
  int unsigned stall_left = 0;
  int unsigned kind_cnt [4] = '{0, 0, 0, 0};
  int unsigned status_cnt [4] = '{0, 0, 0, 0};
  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          tx_calm = 1'b0;

  // Apply one request to the mirror and return what the engine must report.
  // A zero position is rejected for every kind, even before the full check.
  function automatic outcome_t list_op_outcome(request_t rq);
    outcome_t o;
    int       slot;
    o.read_value = '0;
    o.status     = ST_DONE;
    if (rq.position == 0) begin
      o.status = ST_BADPOS;
    end else if (rq.kind == KIND_INSERT) begin
      if (mirror_len >= ListDepth) begin
        o.status = ST_FULL;
      end else begin
        // Positions past the end append.
        slot = (rq.position > mirror_len) ? mirror_len : int'(rq.position) - 1;
        for (int i = mirror_len; i > slot; i--) mirror_words[i] = mirror_words[i-1];
        mirror_words[slot] = rq.new_value;
        mirror_len++;
      end
    end else if (rq.position > mirror_len) begin
      o.status = ST_BADPOS;
    end else begin
      slot = int'(rq.position) - 1;
      case (rq.kind)
        KIND_DELETE: begin
          o.read_value = mirror_words[slot];
          for (int i = slot; i + 1 < mirror_len; i++) mirror_words[i] = mirror_words[i+1];
          mirror_len--;
        end
        KIND_GET: begin
          o.read_value = mirror_words[slot];
        end
        default: begin
          mirror_words[slot] = rq.new_value;
        end
      endcase
    end
    o.list_length = mirror_len[PosWidth-1:0];
    return o;
  endfunction

  // Request side, sampling: a transaction at this edge updates the mirror and
  // leaves its expected result behind.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      awaited_results.push_back(list_op_outcome(offered_request));
      kind_cnt[offered_request.kind]++;
      if (mirror_len > peak_len) peak_len = mirror_len;
      accepted_cnt++;
      req_taken = 1'b1;
    end
  end

  // Request side, driving: hold the offered request until it is taken, then
  // idle for the next request's gap before offering it. A request marked for
  // draining also waits until every outstanding result has come back.
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_requests.size() != 0 && gap_waited >= pending_requests[0].gap &&
          !(pending_requests[0].drain && awaited_results.size() != 0)) begin
        offered_request = pending_requests.pop_front();
        gap_waited      = 0;
        s_axis_tvalid  <= 1'b1;
        s_axis_tdata   <= {7'b0, offered_request.new_value, offered_request.position};
        s_axis_tuser   <= offered_request.kind;
      end else begin
        if (pending_requests.size() != 0 && gap_waited < pending_requests[0].gap) begin
          gap_waited++;
        end
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      error_cnt++;
      if (error_cnt <= MaxReports) begin
        $display("[%0t] result %0d: %s expected 0x%08h, got 0x%08h",
                 $realtime, results_seen, name, exp_val, act_val);
      end
    end
  endtask

  // Result side, sampling: every result transaction is checked against the
  // oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      res_taken = 1'b1;
      if (awaited_results.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MaxReports) begin
          $display("[%0t] result %0d arrived with nothing outstanding, data 0x%012h",
                   $realtime, results_seen, m_axis_tdata);
        end
      end else begin
        wanted = awaited_results.pop_front();
        status_cnt[wanted.status]++;
        report_field("read_value", wanted.read_value, m_axis_tdata[31:0]);
        report_field("status", 32'(wanted.status), 32'(m_axis_tdata[33:32]));
        report_field("list_length", 32'(wanted.list_length), 32'(m_axis_tdata[42:34]));
      end
    end
  end

  // Result side, driving: after each result draw a random stall, spent while
  // the next result waits. Every third block of 60 results runs with the
  // receiver always ready.
  always @(negedge clk) begin
    if (!rst) begin
      if (res_taken) begin
        res_taken  = 1'b0;
        stall_left = ((results_seen / 60) % 3 == 2) ? 0 : $urandom_range(0, 15);
      end
      if (stall_left != 0 && m_axis_tvalid) stall_left--;
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, awaited_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // The queue is kept short so that random positions can follow the mirror.
  task automatic queue_request(input logic [1:0] kind, input int unsigned pos,
                               input logic [31:0] value, input bit drain);
    request_t rq;
    while (pending_requests.size() >= 2) @(posedge clk);
    rq.kind      = kind;
    rq.position  = pos[PosWidth-1:0];
    rq.new_value = value;
    rq.drain     = drain;
    rq.gap       = tx_calm ? 0 : $urandom_range(0, 15);
    pending_requests.push_back(rq);
    queued_cnt++;
  endtask

  // Weighted random request. Most positions land in or just past the list;
  // some are zero and some span the whole field.
  task automatic random_request(input int unsigned insert_w, input int unsigned delete_w);
    int unsigned roll;
    int unsigned pos;
    logic [1:0]  kind;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    if (roll < insert_w) kind = KIND_INSERT;
    else if (roll < insert_w + delete_w) kind = KIND_DELETE;
    else if (roll[0]) kind = KIND_GET;
    else kind = KIND_UPDATE;
    case ($urandom_range(0, 19))
      0:       pos = 0;
      1:       pos = $urandom_range(0, 511);
      default: pos = $urandom_range(1, mirror_len + 2);
    endcase
    case ($urandom_range(0, 11))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      2:       value = 32'hFFFF_FFFF;
      3:       value = 32'h0000_0000;
      default: value = $urandom;
    endcase
    queue_request(kind, pos, value, 1'b0);
  endtask

  initial begin
    int unsigned fill_cnt;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: an empty list rejects every access, zero positions are
    // rejected for all kinds, inserts past the end append, and reads and
    // writes are tried at both ends of the list.
    queue_request(KIND_GET,    1,   32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 1,   32'h0000_0000, 1'b0);
    queue_request(KIND_UPDATE, 1,   32'h1234_5678, 1'b0);
    queue_request(KIND_INSERT, 0,   32'h1111_1111, 1'b0);
    queue_request(KIND_INSERT, 1,   32'h7FFF_FFFF, 1'b0);
    queue_request(KIND_INSERT, 511, 32'h8000_0000, 1'b0);
    queue_request(KIND_INSERT, 1,   32'hFFFF_FFFF, 1'b0);
    queue_request(KIND_INSERT, 2,   32'h0000_0000, 1'b0);
    queue_request(KIND_GET,    1,   32'h0000_0000, 1'b0);
    queue_request(KIND_GET,    4,   32'h0000_0000, 1'b0);
    queue_request(KIND_GET,    5,   32'h0000_0000, 1'b0);
    queue_request(KIND_UPDATE, 2,   32'h5555_5555, 1'b0);
    queue_request(KIND_GET,    2,   32'h0000_0000, 1'b0);
    queue_request(KIND_UPDATE, 0,   32'hAAAA_AAAA, 1'b0);
    queue_request(KIND_DELETE, 0,   32'h0000_0000, 1'b0);
    queue_request(KIND_GET,    0,   32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 4,   32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 1,   32'h0000_0000, 1'b0);
    queue_request(KIND_GET,    256, 32'h0000_0000, 1'b0);
    queue_request(KIND_UPDATE, 511, 32'hFFFF_FFFF, 1'b0);
    queue_request(KIND_INSERT, 3,   32'hAAAA_AAAA, 1'b0);
    queue_request(KIND_DELETE, 3,   32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 2,   32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 1,   32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 1,   32'h0000_0000, 1'b0);

    // Random mix that grows the list, with a stretch of back-to-back requests.
    for (int n = 0; n < 130; n++) begin
      tx_calm = (n >= 40 && n < 70);
      random_request(45, 25);
    end
    tx_calm = 1'b0;

    // Fill to capacity. The mirror is current once everything queued has
    // been accepted, which tells how many inserts reach full. The first
    // insert waits for the engine to drain completely.
    while (accepted_cnt != queued_cnt) @(posedge clk);
    fill_cnt = ListDepth - mirror_len + 4;
    for (int n = 0; n < fill_cnt; n++) begin
      tx_calm = (n % 80) >= 50;
      queue_request(KIND_INSERT, (n % 9 == 0) ? $urandom_range(1, 511)
                                              : $urandom_range(1, mirror_len + 1),
                    $urandom, n == 0);
    end
    tx_calm = 1'b0;

    // At capacity: a zero position beats the full check, and the last slot is
    // reachable while one past it is not.
    queue_request(KIND_INSERT, 0,   32'h0F0F_0F0F, 1'b0);
    queue_request(KIND_GET,    256, 32'h0000_0000, 1'b0);
    queue_request(KIND_UPDATE, 256, 32'h8000_0000, 1'b0);
    queue_request(KIND_GET,    257, 32'h0000_0000, 1'b0);
    queue_request(KIND_DELETE, 256, 32'h0000_0000, 1'b0);
    queue_request(KIND_INSERT, 300, 32'h7FFF_FFFF, 1'b0);
    queue_request(KIND_INSERT, 1,   32'h0000_0001, 1'b0);
    queue_request(KIND_DELETE, 1,   32'h0000_0000, 1'b0);
    queue_request(KIND_GET,    1,   32'h0000_0000, 1'b0);

    // Random mix that shrinks the list again.
    for (int n = 0; n < 140; n++) begin
      tx_calm = (n >= 90 && n < 115);
      random_request(15, 50);
    end
    tx_calm = 1'b0;

    while (accepted_cnt != queued_cnt) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests (%0d insert, %0d delete, %0d get, %0d update), peak length %0d.",
             accepted_cnt, kind_cnt[KIND_INSERT], kind_cnt[KIND_DELETE],
             kind_cnt[KIND_GET], kind_cnt[KIND_UPDATE], peak_len);
    $display("Checked %0d results: %0d done, %0d bad position, %0d full; %0d mismatches.",
             results_seen, status_cnt[ST_DONE], status_cnt[ST_BADPOS],
             status_cnt[ST_FULL], error_cnt);
    if (error_cnt == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* positional_list_engine.f */
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_tap_tree.sv
rtl/positional_list_engine.sv
dv/tb_positional_list_engine.sv
